### design/sld_pkg.sv
// Shared types, constants and the CRC byte update for the sync/length/CRC deframer.
// Depends on nothing; every module of the deframer imports it.
`default_nettype none

package sld_pkg;

	localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
	localparam logic [7:0]  SYNC_SECOND = 8'h5A;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'h1021;

	// Header offsets of the little-endian payload length.
	localparam int OFF_LEN_LO = 4;
	localparam int OFF_LEN_HI = 5;

	// Width of a frame length: header plus a 16-bit payload length plus two CRC bytes.
	localparam int TOTAL_W = 17;
	localparam int CFG_W   = 9;

	typedef enum logic [2:0] {
		ST_MORE      = 3'd0,
		ST_GOOD      = 3'd1,
		ST_CRC_BAD   = 3'd2,
		ST_WRONG_LEN = 3'd3,
		ST_TOO_LONG  = 3'd4,
		ST_SYNC_LOST = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic [7:0]  byte_offset;
		logic        frame_end;
		status_t     frame_status;
		logic [31:0] good_frames;
		logic [31:0] crc_failures;
	} result_t;

	// CRC-16/CCITT-FALSE over one byte, MSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### design/sld_in_stage.sv
// Input register of the deframer: holds one received byte until the core takes it.
// Depends on sld_pkg.
`default_nettype none

module sld_in_stage
	import sld_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// A new byte may enter when the stage is empty or its byte moves on this cycle.
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

`default_nettype wire

### design/sld_frame_core.sv
// Frame state of the deframer: sync hunt, length latch, running CRC and counters.
// Depends on sld_pkg for the CRC update, status codes and the result type.
`default_nettype none

module sld_frame_core
	import sld_pkg::*;
#(
	parameter int BUFFER_BYTES = 256,
	parameter int HEADER_BYTES = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       rx_byte,
	input  wire logic [CFG_W-1:0] frame_len_cfg,
	output logic                  res_valid,
	output result_t               res
);

	localparam int FW = $clog2(BUFFER_BYTES);

	logic [FW-1:0]      fill_q, fill_d;
	logic [15:0]        crc_q, crc_d;
	logic [15:0]        plen_q, plen_d;
	logic [7:0]         crc_lo_q, crc_lo_d;
	logic [31:0]        good_q, good_d;
	logic [31:0]        bad_q, bad_d;

	logic               is_first;
	logic [FW:0]        fill_inc;
	logic [15:0]        crc_base, crc_new, plen_base, plen_new;
	logic [7:0]         lo_base, lo_new;
	logic [TOTAL_W-1:0] crc_end_pos, total, off_t, inc_t;
	logic               crc_upd, past_hdr, at_end, too_long, len_ok, crc_ok;
	status_t            st;
	logic               fend;

	assign is_first  = (fill_q == '0);
	assign fill_inc  = {1'b0, fill_q} + (FW + 1)'(1);
	assign crc_base  = is_first ? CRC_INIT : crc_q;
	assign plen_base = is_first ? 16'h0000 : plen_q;
	assign lo_base   = is_first ? 8'h00 : crc_lo_q;

	always_comb begin
		plen_new = plen_base;
		if (fill_q == FW'(OFF_LEN_LO)) begin
			plen_new = {plen_base[15:8], rx_byte};
		end else if (fill_q == FW'(OFF_LEN_HI)) begin
			plen_new = {rx_byte, plen_base[7:0]};
		end
	end

	// The CRC covers every byte before the two trailing CRC bytes.
	assign crc_end_pos = TOTAL_W'(HEADER_BYTES) + TOTAL_W'(plen_new);
	assign total       = crc_end_pos + TOTAL_W'(2);
	assign off_t       = TOTAL_W'(fill_q);
	assign inc_t       = TOTAL_W'(fill_inc);
	assign crc_upd     = (off_t < TOTAL_W'(HEADER_BYTES)) || (off_t < crc_end_pos);
	assign crc_new     = crc_upd ? crc_byte(crc_base, rx_byte) : crc_base;
	assign lo_new      = (!crc_upd && off_t == crc_end_pos) ? rx_byte : lo_base;
	assign past_hdr    = (inc_t >= TOTAL_W'(HEADER_BYTES));
	assign at_end      = past_hdr && (inc_t == total);
	assign too_long    = past_hdr && !at_end && (total > TOTAL_W'(BUFFER_BYTES));
	assign len_ok      = (TOTAL_W'(frame_len_cfg) == total);
	assign crc_ok      = ({rx_byte, lo_new} == crc_new);

	always_comb begin
		fill_d    = fill_q;
		crc_d     = crc_q;
		plen_d    = plen_q;
		crc_lo_d  = crc_lo_q;
		good_d    = good_q;
		bad_d     = bad_q;
		res_valid = 1'b0;
		st        = ST_MORE;
		fend      = 1'b0;
		priority if (is_first && rx_byte != SYNC_FIRST) begin
			// Still hunting: the byte is dropped silently.
			res_valid = 1'b0;
		end else if (fill_q == FW'(1) && rx_byte != SYNC_SECOND) begin
			res_valid = 1'b1;
			fend      = 1'b1;
			st        = ST_SYNC_LOST;
			fill_d    = '0;
		end else begin
			res_valid = 1'b1;
			crc_d     = crc_new;
			plen_d    = plen_new;
			crc_lo_d  = lo_new;
			fill_d    = fill_inc[FW-1:0];
			if (at_end) begin
				fend   = 1'b1;
				fill_d = '0;
				if (!len_ok) begin
					st = ST_WRONG_LEN;
				end else if (crc_ok) begin
					st     = ST_GOOD;
					good_d = good_q + 32'd1;
				end else begin
					st    = ST_CRC_BAD;
					bad_d = bad_q + 32'd1;
				end
			end else if (too_long) begin
				fend   = 1'b1;
				st     = ST_TOO_LONG;
				fill_d = '0;
			end
		end
		res.frame_byte   = rx_byte;
		res.byte_offset  = 8'(fill_q);
		res.frame_end    = fend;
		res.frame_status = st;
		res.good_frames  = good_d;
		res.crc_failures = bad_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			crc_q    <= CRC_INIT;
			plen_q   <= '0;
			crc_lo_q <= '0;
			good_q   <= '0;
			bad_q    <= '0;
		end else if (step) begin
			fill_q   <= fill_d;
			crc_q    <= crc_d;
			plen_q   <= plen_d;
			crc_lo_q <= crc_lo_d;
			good_q   <= good_d;
			bad_q    <= bad_d;
		end
	end

`ifndef ASSERT_OFF
	a_fill_in_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		TOTAL_W'(fill_q) < TOTAL_W'(BUFFER_BYTES))
		else $error("fill index ran past the buffer");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid && res.frame_end |=> fill_q == '0)
		else $error("frame end did not return to sync hunt");

	a_silent_only_hunting: assert property (@(posedge clk) disable iff (!arst_n)
		step && !res_valid |-> is_first ##1 fill_q == '0)
		else $error("byte dropped outside sync hunt");

	a_good_count_on_good: assert property (@(posedge clk) disable iff (!arst_n)
		step && !(res_valid && res.frame_status == ST_GOOD) |=> $stable(good_q))
		else $error("good counter moved without a good frame");
`endif

endmodule

`default_nettype wire

### design/sld_out_stage.sv
// Result register of the deframer: holds one result until the sink takes it.
// Depends on sld_pkg for the result type.
`default_nettype none

module sld_out_stage
	import sld_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res,
	output logic         can_load,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	output logic [79:0]  m_tdata,
	output logic [2:0]   m_tuser,
	output logic         m_tlast
);

	result_t res_q;

	assign can_load = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tdata = {res_q.crc_failures, res_q.good_frames, res_q.byte_offset, res_q.frame_byte};
	assign m_tuser = res_q.frame_status;
	assign m_tlast = res_q.frame_end;

endmodule

`default_nettype wire

### design/sync_length_crc_deframer.sv
// Top level of the byte-stream deframer with sync hunt, length field and CRC-16 check.
// Depends on sld_pkg, sld_in_stage, sld_frame_core and sld_out_stage.
`default_nettype none

// The deframer takes one received byte per transaction and hunts for the sync
// pair A5 5A. Header bytes 4 and 5 carry the little-endian payload length, and
// a frame spans the header, the payload and a trailing little-endian
// CRC-16/CCITT-FALSE taken over header and payload. Every byte of a frame,
// from the first sync byte on, comes back as one result transaction with its
// offset; bytes seen while hunting give no result. The result that closes or
// aborts a frame has tlast high and a status in tuser: good, CRC mismatch,
// total length other than the configured one, longer than the buffer, or
// second sync byte missing. Both frame counters wrap at 32 bits. The block
// sustains one byte per clock cycle while the sink takes every result: a
// byte passes an input register and then the frame state update (one byte
// of CRC, the length add and compares) writes the result register. While a
// result waits in the result register, one more byte can still enter the
// input register; s_tready then stays low until the sink takes the result
// and rises in the same cycle as m_tready. The user must write the frame
// length register through its own port only while no frame traffic is in
// flight; the block itself does not enforce this. A write takes effect on
// the next byte.

module sync_length_crc_deframer
	import sld_pkg::*;
#(
	parameter int BUFFER_BYTES = 256,
	parameter int HEADER_BYTES = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// Received bytes. s_tdata: [7:0] rx_byte.
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [7:0]       s_tdata,
	// Results. m_tdata: [7:0] frame_byte, [15:8] byte_offset,
	// [47:16] good_frames, [79:48] crc_failures. m_tuser: [2:0] frame_status.
	// m_tlast: frame_end.
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [79:0]           m_tdata,
	output logic [2:0]            m_tuser,
	output logic                  m_tlast,
	// Accepted total frame length register.
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             can_load;
	logic             advance;
	logic             res_valid;
	result_t          res;
	logic [CFG_W-1:0] frame_len_q;

	// A byte leaves the input register whenever the result register can take
	// whatever it produces.
	assign advance = valid_s1 && can_load;

	// The length register is always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= CFG_W'(134);
		end else if (cfg_valid && cfg_ready) begin
			frame_len_q <= cfg_data;
		end
	end

	sld_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	sld_frame_core #(
		.BUFFER_BYTES (BUFFER_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.rx_byte       (byte_s1),
		.frame_len_cfg (frame_len_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	sld_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && res_valid),
		.res      (res),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
